[hw/rtl/brg_pkg.sv]
package brg_pkg;

	localparam int GRID_POINTS = 64;
	localparam int IDX_W = $clog2(GRID_POINTS);
	localparam int CNT_W = IDX_W + 1;
	localparam int VAL_W = 16;
	localparam int STEP_W = 10;
	localparam int ACOEF_W = 16;
	localparam int DCOEF_W = 15;
	localparam int CFG_W = 16;

	localparam logic [1:0] REG_STEP_COUNT = 2'd0;
	localparam logic [1:0] REG_ADVECT = 2'd1;
	localparam logic [1:0] REG_DIFFUSE = 2'd2;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_RUN = 1'b1;

	localparam logic [STEP_W-1:0] STEP_RST = 10'd100;
	localparam logic [ACOEF_W-1:0] ADVECT_RST = 16'd5215;
	localparam logic [DCOEF_W-1:0] DIFFUSE_RST = 15'd8322;

	typedef logic signed [VAL_W-1:0] val_t;

	// per-cell control from the sequencer
	typedef struct packed {
		logic wr;
		logic shift;
		logic tail;
	} cell_ctl_t;

	typedef enum logic [1:0] {
		PH_MUL = 2'd0,
		PH_MUL2 = 2'd1,
		PH_SUM = 2'd2
	} phase_t;

endpackage

[hw/rtl/brg_cell.sv]
module brg_cell (
	input  logic               clk,
	input  brg_pkg::cell_ctl_t ctl,
	input  brg_pkg::val_t      load_data,
	input  brg_pkg::val_t      from_right,
	input  brg_pkg::val_t      tail_data,
	output brg_pkg::val_t      q
);
	import brg_pkg::*;

	val_t q_q;

	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			q_q <= load_data;
		end else if (ctl.shift) begin
			// the tail cell closes the ring
			q_q <= ctl.tail ? tail_data : from_right;
		end
	end

	assign q = q_q;

endmodule

[hw/rtl/brg_pe.sv]
module brg_pe (
	input  logic                                clk,
	input  brg_pkg::val_t                       ul,
	input  brg_pkg::val_t                       u,
	input  brg_pkg::val_t                       ur,
	input  logic [brg_pkg::ACOEF_W-1:0]         a,
	input  logic [brg_pkg::DCOEF_W-1:0]         d,
	output brg_pkg::val_t                       nv
);
	import brg_pkg::*;

	logic signed [32:0] au_s1;
	logic signed [16:0] du_s1;
	logic signed [33:0] dl_s1;
	logic signed [49:0] adv_s2;
	logic signed [33:0] dl_s2;
	logic signed [17:0] lap;
	logic signed [51:0] total;
	logic signed [25:0] r;

	assign lap = 18'(ur) - (18'(u) <<< 1) + 18'(ul);

	// inputs stay put over the three phases of a point
	always_ff @(posedge clk) begin
		au_s1 <= 33'($signed({1'b0, a})) * 33'(u);
		du_s1 <= 17'(u) - 17'(ul);
		dl_s1 <= 34'($signed({1'b0, d})) * 34'(lap);
		adv_s2 <= 50'(au_s1) * 50'(du_s1);
		dl_s2 <= dl_s1;
	end

	always_comb begin
		total = (52'(u) <<< 26) - 52'(adv_s2) + (52'(dl_s2) <<< 10)
			+ (52'sd1 <<< 25);
		r = 26'(total >>> 26);
		if (r > 26'sd32767) begin
			nv = 16'sh7fff;
		end else if (r < -26'sd32768) begin
			nv = 16'sh8000;
		end else begin
			nv = 16'(r);
		end
	end

endmodule

[hw/rtl/burgers_1d_ftcs_stepper.sv]
// Load: one sample per cycle, no result.
// Run: busy through ring priming, the MUL, MUL2 and SUM phases of every point and step
// in the shared update unit, then output.
// Results come one per cycle in grid order and cannot be held off by the receiver.
// Too few points: one error result the cycle after the run is taken.
// Reset clears control and sets configuration to its defaults; grid cells keep no reset value.
module burgers_1d_ftcs_stepper (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          cmd,
	input  brg_pkg::val_t                 sample,
	input  logic                          last_sample,
	input  logic                          cfg_we,
	input  logic [1:0]                    cfg_index,
	input  logic [brg_pkg::CFG_W-1:0]     cfg_data,
	output logic                          done,
	output brg_pkg::val_t                 value,
	output logic                          last_value,
	output logic                          error
);
	import brg_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_PREP = 4'b0010,
		S_STEP = 4'b0100,
		S_EMIT = 4'b1000
	} state_t;

	state_t state_q;
	logic [STEP_W-1:0] steps_q, step_q;
	logic [ACOEF_W-1:0] a_q;
	logic [DCOEF_W-1:0] d_q;
	logic [CNT_W-1:0] pc_q, li_q, li_next;
	logic [IDX_W-1:0] pt_q, nm1;
	phase_t ph_q;
	val_t last_old_q, first_old_q, prev_q;
	val_t cells [GRID_POINTS];
	cell_ctl_t ctl [GRID_POINTS];
	val_t ul, ur, nv, tail_data;
	logic accept, rotate, pt_last, err_run;
	logic done_q, last_q, err_q;
	val_t value_q;

	assign accept = start && !busy;
	assign busy = state_q != S_IDLE;
	assign nm1 = IDX_W'(pc_q - CNT_W'(1));
	assign pt_last = pt_q == nm1;
	assign li_next = (li_q < CNT_W'(GRID_POINTS)) ? li_q + CNT_W'(1) : li_q;
	assign err_run = accept && cmd == CMD_RUN && pc_q < CNT_W'(3);

	assign rotate = (state_q == S_PREP) || (state_q == S_EMIT)
		|| (state_q == S_STEP && ph_q == PH_SUM);
	assign tail_data = (state_q == S_STEP) ? nv : cells[0];

	assign ul = (pt_q == '0) ? last_old_q : prev_q;
	assign ur = pt_last ? first_old_q : cells[1];

	for (genvar i = 0; i < GRID_POINTS; i++) begin : g_ring
		always_comb begin
			ctl[i].wr = accept && cmd == CMD_LOAD && li_q < CNT_W'(GRID_POINTS)
				&& li_q[IDX_W-1:0] == IDX_W'(i);
			ctl[i].shift = rotate && IDX_W'(i) <= nm1;
			ctl[i].tail = IDX_W'(i) == nm1;
		end
		brg_cell u_cell (
			.clk(clk),
			.ctl(ctl[i]),
			.load_data(sample),
			.from_right(cells[(i + 1) % GRID_POINTS]),
			.tail_data(tail_data),
			.q(cells[i])
		);
	end

	brg_pe u_pe (
		.clk(clk),
		.ul(ul),
		.u(cells[0]),
		.ur(ur),
		.a(a_q),
		.d(d_q),
		.nv(nv)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steps_q <= STEP_RST;
			a_q <= ADVECT_RST;
			d_q <= DIFFUSE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_STEP_COUNT: steps_q <= cfg_data[STEP_W-1:0];
				REG_ADVECT: a_q <= cfg_data[ACOEF_W-1:0];
				REG_DIFFUSE: d_q <= cfg_data[DCOEF_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (rotate) begin
			prev_q <= cells[0];
			if (pt_q == '0) begin
				first_old_q <= cells[0];
			end
			// keep the value the ring tail takes: the left of point 0 next pass
			if (pt_last && state_q != S_EMIT) begin
				last_old_q <= tail_data;
			end
		end
		value_q <= (state_q == S_EMIT) ? cells[0] : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pc_q <= '0;
			li_q <= '0;
			pt_q <= '0;
			step_q <= '0;
			ph_q <= PH_MUL;
			done_q <= 1'b0;
			last_q <= 1'b0;
			err_q <= 1'b0;
		end else begin
			done_q <= err_run || state_q == S_EMIT;
			last_q <= err_run || (state_q == S_EMIT && pt_last);
			err_q <= err_run;
			case (state_q)
				S_IDLE: begin
					if (accept && cmd == CMD_LOAD) begin
						if (last_sample) begin
							pc_q <= li_next;
							li_q <= '0;
						end else begin
							li_q <= li_next;
						end
					end else if (accept) begin
						li_q <= '0;
						pt_q <= '0;
						step_q <= '0;
						ph_q <= PH_MUL;
						if (pc_q >= CNT_W'(3)) begin
							state_q <= S_PREP;
						end
					end
				end
				S_PREP: begin
					if (pt_last) begin
						pt_q <= '0;
						state_q <= (steps_q == '0) ? S_EMIT : S_STEP;
					end else begin
						pt_q <= pt_q + IDX_W'(1);
					end
				end
				S_STEP: begin
					case (ph_q)
						PH_MUL: ph_q <= PH_MUL2;
						PH_MUL2: ph_q <= PH_SUM;
						PH_SUM: begin
							ph_q <= PH_MUL;
							if (pt_last) begin
								pt_q <= '0;
								step_q <= step_q + STEP_W'(1);
								if (step_q == steps_q - STEP_W'(1)) begin
									state_q <= S_EMIT;
								end
							end else begin
								pt_q <= pt_q + IDX_W'(1);
							end
						end
						default: ph_q <= PH_MUL;
					endcase
				end
				S_EMIT: begin
					if (pt_last) begin
						pt_q <= '0;
						state_q <= S_IDLE;
					end else begin
						pt_q <= pt_q + IDX_W'(1);
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign done = done_q;
	assign value = value_q;
	assign last_value = last_q;
	assign error = err_q;

	a_err_shape: assert property (@(posedge clk) disable iff (!arst_n)
		error |-> done && last_value && value == '0)
		else $error("error result malformed");
	a_ph_legal: assert property (@(posedge clk) disable iff (!arst_n)
		ph_q != 2'd3)
		else $error("phase out of range");
	a_pt_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE |-> pt_q <= nm1)
		else $error("point index past grid");
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EMIT && pt_last |=> state_q == S_IDLE && done && last_value)
		else $error("run did not end on last result");

endmodule

[dv/testbench.sv]
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import brg_pkg::*;

	localparam int WATCHDOG_LIMIT = 60000;

	typedef struct {
		val_t value;
		logic last;
		logic err;
	} grid_out_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic cmd = CMD_LOAD;
	val_t sample = '0;
	logic last_sample = 1'b0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = REG_STEP_COUNT;
	logic [CFG_W-1:0] cfg_data = '0;
	logic done;
	val_t value;
	logic last_value;
	logic error;

	burgers_1d_ftcs_stepper uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.sample(sample), .last_sample(last_sample), .cfg_we(cfg_we),
		.cfg_index(cfg_index), .cfg_data(cfg_data), .done(done), .value(value),
		.last_value(last_value), .error(error)
	);

	always #1 clk = ~clk;

	// shadow of the grid and its registers
	int grid[GRID_POINTS];
	int scratch[GRID_POINTS];
	int unsigned n_points = 0;
	int unsigned load_pos = 0;
	int unsigned steps = STEP_RST;
	int unsigned acoef = ADVECT_RST;
	int unsigned dcoef = DIFFUSE_RST;

	grid_out_t grid_out_q[$];
	int mismatches = 0;
	int idle_pct = 0;
	int quiet_cycles = 0;

	function automatic int ftcs_point(int ul, int u, int ur);
		longint adv, dif, total, r;
		adv = longint'(acoef) * longint'(u) * longint'(u - ul);
		dif = longint'(dcoef) * longint'(ur - 2 * u + ul) * 1024;
		total = longint'(u) * 67108864 - adv + dif;
		r = (total + 33554432) >>> 26;
		if (r > 32767) r = 32767;
		if (r < -32768) r = -32768;
		return int'(r);
	endfunction

	function automatic void predict(logic c, val_t s, logic l);
		grid_out_t o;
		int lf, rt;
		if (c == CMD_LOAD) begin
			if (load_pos < GRID_POINTS) begin
				grid[load_pos] = s;
				load_pos++;
			end
			if (l) begin
				n_points = load_pos;
				load_pos = 0;
			end
			return;
		end
		load_pos = 0;
		if (n_points < 3) begin
			o.value = '0;
			o.last = 1'b1;
			o.err = 1'b1;
			grid_out_q.push_back(o);
			return;
		end
		for (int st = 0; st < steps; st++) begin
			for (int i = 0; i < n_points; i++) begin
				lf = (i == 0) ? n_points - 1 : i - 1;
				rt = (i + 1 == n_points) ? 0 : i + 1;
				scratch[i] = ftcs_point(grid[lf], grid[i], grid[rt]);
			end
			for (int i = 0; i < n_points; i++) grid[i] = scratch[i];
		end
		for (int i = 0; i < n_points; i++) begin
			o.value = val_t'(grid[i]);
			o.last = (i + 1 == n_points);
			o.err = 1'b0;
			grid_out_q.push_back(o);
		end
	endfunction

	// result checker
	always @(posedge clk) begin
		grid_out_t e;
		if (done) begin
			if (grid_out_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result value=%0d last=%b err=%b",
						value, last_value, error);
			end else begin
				e = grid_out_q.pop_front();
				if (value !== e.value || last_value !== e.last || error !== e.err) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result mismatch: exp %0d/%b/%b got %0d/%b/%b",
							e.value, e.last, e.err, value, last_value, error);
				end
			end
		end
	end

	// watchdog on cycles with no transfer in either direction
	always @(posedge clk) begin
		if ((start && !busy) || done)
			quiet_cycles <= 0;
		else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	task automatic send_item(logic c, val_t s, logic l);
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		start <= 1'b1;
		cmd <= c;
		sample <= s;
		last_sample <= l;
		do @(posedge clk); while (busy);
		predict(c, s, l);
	endtask

	// drain all results, then let a trailing load settle
	task automatic settle();
		start <= 1'b0;
		while (grid_out_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, int unsigned data);
		settle();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data[CFG_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_STEP_COUNT: steps = data & 32'h3FF;
			REG_ADVECT: acoef = data & 32'hFFFF;
			REG_DIFFUSE: dcoef = data & 32'h7FFF;
			default: ;
		endcase
	endtask

	task automatic load_grid(int cnt, bit flag);
		for (int i = 0; i < cnt; i++)
			send_item(CMD_LOAD, val_t'($urandom()), flag && (i == cnt - 1));
	endtask

	task automatic test_directed();
		send_item(CMD_RUN, '0, 1'b0);
		send_item(CMD_LOAD, 16'sd100, 1'b0);
		send_item(CMD_LOAD, -16'sd100, 1'b1);
		send_item(CMD_RUN, '0, 1'b0);
		write_reg(REG_STEP_COUNT, 1);
		send_item(CMD_LOAD, 16'sh7FFF, 1'b0);
		send_item(CMD_LOAD, 16'sh8000, 1'b0);
		send_item(CMD_LOAD, 16'sd0, 1'b0);
		send_item(CMD_LOAD, 16'shFFFF, 1'b1);
		send_item(CMD_RUN, '0, 1'b0);
		send_item(CMD_RUN, '0, 1'b1);
		write_reg(REG_STEP_COUNT, 0);
		send_item(CMD_RUN, 16'sh7FFF, 1'b0);
		// partial load keeps the old size over a partly new grid
		send_item(CMD_LOAD, 16'sd1024, 1'b0);
		send_item(CMD_LOAD, -16'sd1024, 1'b0);
		write_reg(REG_STEP_COUNT, 2);
		send_item(CMD_RUN, '0, 1'b0);
	endtask

	task automatic test_coeff_extremes();
		write_reg(REG_ADVECT, 16'hFFFF);
		write_reg(REG_DIFFUSE, 15'h7FFF);
		write_reg(REG_STEP_COUNT, 1023);
		load_grid(4, 1'b1);
		send_item(CMD_RUN, '0, 1'b0);
		write_reg(REG_STEP_COUNT, 3);
		write_reg(REG_ADVECT, 0);
		write_reg(REG_DIFFUSE, 0);
		load_grid(GRID_POINTS, 1'b1);
		send_item(CMD_RUN, '0, 1'b0);
	endtask

	task automatic test_random(int pct, int target);
		int sent;
		int cnt;
		int pick;
		idle_pct = pct;
		sent = 0;
		while (sent < target) begin
			if ($urandom_range(99) < 20) begin
				write_reg(REG_STEP_COUNT, $urandom_range(1, 4));
				write_reg(REG_ADVECT, $urandom_range(0, 65535));
				write_reg(REG_DIFFUSE, $urandom_range(0, 32767));
			end
			pick = $urandom_range(99);
			if (pick < 70) begin
				cnt = ($urandom_range(9) == 0) ? $urandom_range(17, GRID_POINTS)
					: $urandom_range(3, 16);
				load_grid(cnt, 1'b1);
				send_item(CMD_RUN, val_t'($urandom()), 1'($urandom()));
				sent += cnt + 1;
			end else if (pick < 78) begin
				// overflow past the grid size
				cnt = $urandom_range(GRID_POINTS + 1, GRID_POINTS + 6);
				load_grid(cnt, 1'b1);
				send_item(CMD_RUN, '0, 1'b0);
				sent += cnt + 1;
			end else if (pick < 88) begin
				cnt = $urandom_range(1, 5);
				load_grid(cnt, 1'b0);
				send_item(CMD_RUN, '0, 1'b0);
				sent += cnt + 1;
			end else begin
				cnt = $urandom_range(1, 2);
				load_grid(cnt, 1'b1);
				send_item(CMD_RUN, '0, 1'b0);
				sent += cnt + 1;
			end
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_coeff_extremes();
		test_random(9, 125);
		test_random(72, 125);
		test_random(0, 125);
		settle();
		repeat (20) @(posedge clk);
		if (mismatches == 0 && grid_out_q.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

[files.f]
hw/rtl/brg_pkg.sv
hw/rtl/brg_cell.sv
hw/rtl/brg_pe.sv
hw/rtl/burgers_1d_ftcs_stepper.sv
dv/testbench.sv
